// ----- rtl/knn_pkg.sv -----
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants of the k-nearest-neighbor distance selector.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

  // Field widths.
  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned POINT_ID_BITS = 17;
  localparam int unsigned DIST_BITS     = 34;
  localparam int unsigned RANK_BITS     = 4;
  localparam int unsigned COUNT_BITS    = 5;
  localparam int unsigned SQUARE_BITS   = 2 * COORD_BITS;

  // Depth of the neighbor list and distance held by empty slots after reset.
  localparam int unsigned MAX_NEIGHBORS = 16;
  localparam logic [DIST_BITS-1:0] CEILING_RESET = 34'd100000;

  // Queue between the distance front end and the insertion back end.
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

  // Register port.
  localparam int unsigned APB_ADDR_BITS = 6;
  localparam int unsigned APB_DATA_BITS = 64;

  // Register indexes, one per 64-bit slot.
  typedef enum logic [2:0] {
    REG_QUERY_X          = 3'd0,
    REG_QUERY_Y          = 3'd1,
    REG_QUERY_Z          = 3'd2,
    REG_NEIGHBOR_COUNT   = 3'd3,
    REG_DISTANCE_CEILING = 3'd4
  } knn_reg_e;

  // Back end sequencer states.
  typedef enum logic {
    ST_INSERT,
    ST_EMIT
  } knn_state_e;

  // Candidate word as it enters the block.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [POINT_ID_BITS-1:0]     point_id;
    logic                         last_candidate;
  } knn_point_t;

  // Ranked result word.
  typedef struct packed {
    logic [RANK_BITS-1:0]     rank;
    logic [POINT_ID_BITS-1:0] neighbor_id;
    logic [DIST_BITS-1:0]     squared_distance;
    logic                     last_result;
  } knn_result_t;

  // Scored candidate held in the queue.
  typedef struct packed {
    logic [DIST_BITS-1:0]     sq_dist;
    logic [POINT_ID_BITS-1:0] id;
    logic                     last;
  } knn_cand_t;

  // Register contents seen by the datapath.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
    logic [COUNT_BITS-1:0]        neighbor_count;
    logic [DIST_BITS-1:0]         distance_ceiling;
  } knn_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/knn_regs.sv -----
// ----------------------------------------------------------------------------
// knn_regs
// Register file behind the APB-style port: query point, K and ceiling.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [knn_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [knn_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [knn_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                    pready,
  output knn_pkg::knn_cfg_t                       cfg_o
);

  knn_pkg::knn_cfg_t cfg_q;
  knn_pkg::knn_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = knn_pkg::knn_reg_e'(paddr[5:3]);

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.query_x          <= '0;
      cfg_q.query_y          <= '0;
      cfg_q.query_z          <= '0;
      cfg_q.neighbor_count   <= knn_pkg::COUNT_BITS'(1);
      cfg_q.distance_ceiling <= knn_pkg::CEILING_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        knn_pkg::REG_QUERY_X: begin
          cfg_q.query_x <= pwdata[knn_pkg::COORD_BITS-1:0];
        end
        knn_pkg::REG_QUERY_Y: begin
          cfg_q.query_y <= pwdata[knn_pkg::COORD_BITS-1:0];
        end
        knn_pkg::REG_QUERY_Z: begin
          cfg_q.query_z <= pwdata[knn_pkg::COORD_BITS-1:0];
        end
        knn_pkg::REG_NEIGHBOR_COUNT: begin
          cfg_q.neighbor_count <= pwdata[knn_pkg::COUNT_BITS-1:0];
        end
        knn_pkg::REG_DISTANCE_CEILING: begin
          cfg_q.distance_ceiling <= pwdata[knn_pkg::DIST_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back, zero extended.
  always_comb begin
    prdata = '0;
    case (reg_sel)
      knn_pkg::REG_QUERY_X: begin
        prdata = knn_pkg::APB_DATA_BITS'(unsigned'(cfg_q.query_x));
      end
      knn_pkg::REG_QUERY_Y: begin
        prdata = knn_pkg::APB_DATA_BITS'(unsigned'(cfg_q.query_y));
      end
      knn_pkg::REG_QUERY_Z: begin
        prdata = knn_pkg::APB_DATA_BITS'(unsigned'(cfg_q.query_z));
      end
      knn_pkg::REG_NEIGHBOR_COUNT: begin
        prdata = knn_pkg::APB_DATA_BITS'(cfg_q.neighbor_count);
      end
      knn_pkg::REG_DISTANCE_CEILING: begin
        prdata = knn_pkg::APB_DATA_BITS'(cfg_q.distance_ceiling);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/knn_front.sv -----
// ----------------------------------------------------------------------------
// knn_front
// Accepts candidates and scores them with the squared distance to the query
// point in two pipeline stages; holds off input once queue and stages hold 4 words.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_front (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire knn_pkg::knn_point_t                    cand_i,
  input  wire knn_pkg::knn_cfg_t                      cfg_i,
  input  wire logic [knn_pkg::QUEUE_LEVEL_BITS-1:0]   level_i,
  output logic                                        push_o,
  output knn_pkg::knn_cand_t                          push_data_o
);

  localparam int unsigned CB = knn_pkg::COORD_BITS;
  localparam int unsigned SB = knn_pkg::SQUARE_BITS;
  localparam int unsigned DB = knn_pkg::DIST_BITS;
  localparam int unsigned LB = knn_pkg::QUEUE_LEVEL_BITS;

  logic                              accept;
  logic [LB-1:0]                     occupancy;
  logic [CB-1:0]                     mag_x, mag_y, mag_z;
  logic                              a_valid_q;
  logic [CB-1:0]                     a_mag_x_q, a_mag_y_q, a_mag_z_q;
  logic [knn_pkg::POINT_ID_BITS-1:0] a_id_q, b_id_q;
  logic                              a_last_q, b_last_q;
  logic                              b_valid_q;
  logic [SB-1:0]                     b_sq_x_q, b_sq_y_q, b_sq_z_q;

  // Magnitude of one coordinate difference; it always fits in CB bits.
  function automatic logic [CB-1:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB:0] d;
    logic [CB:0] m;
    d = {a[CB-1], a} - {b[CB-1], b};
    m = d[CB] ? ((CB+1)'(0) - d) : d;
    return m[CB-1:0];
  endfunction

  // Every word in flight has a queue slot reserved for it.
  assign occupancy = level_i + LB'(a_valid_q) + LB'(b_valid_q);
  assign busy      = (occupancy >= LB'(knn_pkg::QUEUE_DEPTH));
  assign accept    = start && !busy;

  assign mag_x = abs_diff(cand_i.point_x, cfg_i.query_x);
  assign mag_y = abs_diff(cand_i.point_y, cfg_i.query_y);
  assign mag_z = abs_diff(cand_i.point_z, cfg_i.query_z);

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
    end
  end

  // Stage A holds the magnitudes, stage B the squares.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_mag_x_q <= mag_x;
      a_mag_y_q <= mag_y;
      a_mag_z_q <= mag_z;
      a_id_q    <= cand_i.point_id;
      a_last_q  <= cand_i.last_candidate;
    end
    if (a_valid_q) begin
      b_sq_x_q <= SB'(a_mag_x_q) * SB'(a_mag_x_q);
      b_sq_y_q <= SB'(a_mag_y_q) * SB'(a_mag_y_q);
      b_sq_z_q <= SB'(a_mag_z_q) * SB'(a_mag_z_q);
      b_id_q   <= a_id_q;
      b_last_q <= a_last_q;
    end
  end

  // The three squares sum to less than 2^34, so no saturation is needed.
  assign push_o              = b_valid_q;
  assign push_data_o.sq_dist = DB'(b_sq_x_q) + DB'(b_sq_y_q) + DB'(b_sq_z_q);
  assign push_data_o.id      = b_id_q;
  assign push_data_o.last    = b_last_q;

endmodule

`default_nettype wire

// ----- rtl/knn_fifo.sv -----
// ----------------------------------------------------------------------------
// knn_fifo
// Short queue of scored candidates between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_fifo (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push_i,
  input  wire knn_pkg::knn_cand_t                    push_data_i,
  input  wire logic                                  pop_i,
  output knn_pkg::knn_cand_t                         head_o,
  output logic                                       empty_o,
  output logic [knn_pkg::QUEUE_LEVEL_BITS-1:0]       level_o
);

  localparam int unsigned PB = knn_pkg::QUEUE_PTR_BITS;
  localparam int unsigned LB = knn_pkg::QUEUE_LEVEL_BITS;

  knn_pkg::knn_cand_t slot_q [knn_pkg::QUEUE_DEPTH];
  logic [PB-1:0]      wr_ptr_q, rd_ptr_q;
  logic [LB-1:0]      level_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PB'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PB'(1);
      end
      level_q <= level_q + LB'(push_i) - LB'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign empty_o = (level_q == '0);
  assign level_o = level_q;

  // The front end reserves a slot for every word it accepts.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == LB'(knn_pkg::QUEUE_DEPTH)) |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/knn_back.sv -----
// ----------------------------------------------------------------------------
// knn_back
// Keeps the sorted list of the K nearest candidates with a parallel
// compare-and-shift insertion, and on a last candidate emits the list one
// rank per cycle before clearing it to the ceiling.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire knn_pkg::knn_cfg_t  cfg_i,
  input  wire knn_pkg::knn_cand_t head_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    result_valid_o,
  output knn_pkg::knn_result_t    result_o
);

  localparam int unsigned N  = knn_pkg::MAX_NEIGHBORS;
  localparam int unsigned RB = knn_pkg::RANK_BITS;
  localparam int unsigned KB = knn_pkg::COUNT_BITS;

  knn_pkg::knn_state_e               state_q, state_d;
  logic [RB-1:0]                     rank_q, rank_d;
  logic [RB-1:0]                     last_idx;
  logic [knn_pkg::DIST_BITS-1:0]     dist_q [N];
  logic [knn_pkg::DIST_BITS-1:0]     dist_d [N];
  logic [knn_pkg::POINT_ID_BITS-1:0] id_q [N];
  logic [knn_pkg::POINT_ID_BITS-1:0] id_d [N];
  logic [N-1:0]                      active, closer, ok, run;

  // Index of the K-th slot, with K clamped to 1..N.
  always_comb begin
    if (cfg_i.neighbor_count == '0) begin
      last_idx = '0;
    end else if (cfg_i.neighbor_count > KB'(N)) begin
      last_idx = RB'(N - 1);
    end else begin
      last_idx = RB'(cfg_i.neighbor_count - KB'(1));
    end
  end

  // Per-slot compare; run[i] says the new word beats every active slot from i up.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      active[i] = (RB'(i) <= last_idx);
      closer[i] = (head_i.sq_dist < dist_q[i]);
      ok[i]     = closer[i] || !active[i];
    end
    for (int i = 0; i < N; i++) begin
      run[i] = active[i] && (&(ok | ((N'(1) << i) - N'(1))));
    end
  end

  // Sequencer and list update.
  always_comb begin
    state_d = state_q;
    rank_d  = rank_q;
    pop_o   = 1'b0;
    for (int i = 0; i < N; i++) begin
      dist_d[i] = dist_q[i];
      id_d[i]   = id_q[i];
    end
    case (state_q)
      knn_pkg::ST_INSERT: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (run[0]) begin
            dist_d[0] = head_i.sq_dist;
            id_d[0]   = head_i.id;
          end
          for (int i = 1; i < N; i++) begin
            if (run[i]) begin
              if (run[i-1]) begin
                dist_d[i] = dist_q[i-1];
                id_d[i]   = id_q[i-1];
              end else begin
                dist_d[i] = head_i.sq_dist;
                id_d[i]   = head_i.id;
              end
            end
          end
          if (head_i.last) begin
            state_d = knn_pkg::ST_EMIT;
            rank_d  = '0;
          end
        end
      end
      knn_pkg::ST_EMIT: begin
        rank_d = rank_q + RB'(1);
        if (rank_q == last_idx) begin
          state_d = knn_pkg::ST_INSERT;
          rank_d  = '0;
          for (int i = 0; i < N; i++) begin
            dist_d[i] = cfg_i.distance_ceiling;
            id_d[i]   = '0;
          end
        end
      end
      default: begin
        state_d = knn_pkg::ST_INSERT;
      end
    endcase
  end

  // State, rank counter and the list itself.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= knn_pkg::ST_INSERT;
      rank_q  <= '0;
      for (int i = 0; i < N; i++) begin
        dist_q[i] <= knn_pkg::CEILING_RESET;
        id_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
      for (int i = 0; i < N; i++) begin
        dist_q[i] <= dist_d[i];
        id_q[i]   <= id_d[i];
      end
    end
  end

  // One ranked word per cycle while emitting.
  assign result_valid_o            = (state_q == knn_pkg::ST_EMIT);
  assign result_o.rank             = rank_q;
  assign result_o.neighbor_id      = id_q[rank_q];
  assign result_o.squared_distance = dist_q[rank_q];
  assign result_o.last_result      = (rank_q == last_idx);

  a_rank_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_result) |=>
      (result_valid_o && (result_o.rank == $past(result_o.rank) + RB'(1))))
    else $error("ranks not emitted in order");

  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |=> !result_valid_o)
    else $error("emission ran past the last rank");

  a_list_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q[0] <= dist_q[1])
    else $error("neighbor list out of order");

endmodule

`default_nettype wire

// ----- rtl/knn_top_k_distance_select.sv -----
// ----------------------------------------------------------------------------
// knn_top_k_distance_select
// Streams candidate points and reports the K nearest to a query point.
// ----------------------------------------------------------------------------
// Usage: program the query point, K and the distance ceiling over the APB
// port while the block is idle. Present a candidate word on cand_i with
// start; it is taken at an edge where start is high and busy is low.
// Each candidate is scored in two pipeline stages (coordinate differences,
// then squares), queued, and inserted into the sorted list by the back end,
// one candidate per cycle unless emitting, so candidates are taken back to
// back. On a candidate marked last, K result words follow on result_o, one
// per cycle, each flagged by result_valid_o for a single cycle; the earliest
// follows the insertion of that candidate. While those K words go out the
// back end takes nothing from its 4-word queue, so busy rises once four
// words are in flight in the scoring stages and the queue together.
// After the last rank the list is cleared to the ceiling with index 0.
// The receiver cannot stall.
// Reset clears the list to a ceiling of 100000, sets K to 1 and the query
// point to the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_top_k_distance_select (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire knn_pkg::knn_point_t                cand_i,
  output logic                                    result_valid_o,
  output knn_pkg::knn_result_t                    result_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [knn_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [knn_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [knn_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                    pready
);

  knn_pkg::knn_cfg_t                      cfg;
  knn_pkg::knn_cand_t                     push_data, head;
  logic                                   push, pop, empty;
  logic [knn_pkg::QUEUE_LEVEL_BITS-1:0]   level;

  // Configuration registers.
  knn_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Distance scoring front end.
  knn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cand_i      (cand_i),
    .cfg_i       (cfg),
    .level_i     (level),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue of scored candidates.
  knn_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .level_o     (level)
  );

  // Insertion list and result emission.
  knn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire
